### rtl/bmhq_pkg.sv
// Package of the binary min-heap queue: field widths, status and action codes,
// and the entry and result types. No dependencies.
`default_nettype none

package bmhq_pkg;

	localparam int KEY_W        = 16;
	localparam int TAG_W        = 16;
	localparam int STATUS_W     = 2;
	localparam int FILL_W       = 9;
	localparam int CAPACITY_DEF = 256;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [TAG_W-1:0]    tag;
		logic [STATUS_W-1:0] status;
		logic [FILL_W-1:0]   fill;
	} res_t;

endpackage

`default_nettype wire

### rtl/bmhq_if.sv
// Valid/ready channel interfaces of the heap queue: request and response.
// Depends on bmhq_pkg for the field widths.
`default_nettype none

interface bmhq_req_if import bmhq_pkg::*; ;
	logic             valid;
	logic             ready;
	logic             action;
	logic [KEY_W-1:0] key;
	logic [TAG_W-1:0] tag;

	modport source (output valid, output action, output key, output tag, input ready);
	modport sink (input valid, input action, input key, input tag, output ready);
endinterface

interface bmhq_rsp_if import bmhq_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [KEY_W-1:0]    out_key;
	logic [TAG_W-1:0]    out_tag;
	logic [STATUS_W-1:0] status;
	logic [FILL_W-1:0]   fill_count;

	modport source (output valid, output out_key, output out_tag, output status,
		output fill_count, input ready);
	modport sink (input valid, input out_key, input out_tag, input status,
		input fill_count, output ready);
endinterface

`default_nettype wire

### rtl/binary_min_heap_queue.sv
// Binary min-heap priority queue of key and tag pairs, top level.
// Depends on bmhq_pkg, bmhq_if, bmhq_mem and bmhq_ctrl.
//
// Usage: requests arrive on req (action, key, tag); each request yields exactly
// one response on rsp (out_key, out_tag, status, fill_count), in order.
// An insert stores the pair and sifts it up; a removal returns the smallest key
// and sifts the last entry down from the root. A removal from an empty heap
// reports status empty, an insert into a full heap is dropped with status full.
// One request is worked on at a time and req.ready is low meanwhile. An insert
// climbs one level per pass of reading the parent, then comparing and writing;
// a removal sinks one level per pass of reading both children, picking one,
// comparing and writing. A rejected insert or an empty removal goes straight to
// its response. At the earliest, the next request is accepted in the cycle in
// which rsp.valid rises.
// The response sits in an output register, so the next request is accepted
// while an earlier response waits; if rsp.ready stays low, the following
// response is held inside the block until the register frees.
// Reset empties the heap at once; the entry store itself is not cleared.
`default_nettype none

module binary_min_heap_queue import bmhq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bmhq_req_if.sink  req,
	bmhq_rsp_if.source rsp
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	entry_t        mem_wr_data;
	logic          mem_rd_en;
	logic [AW-1:0] mem_rd_addr;
	entry_t        mem_rd_data;
	logic          res_free;
	logic          res_valid;
	res_t          res;
	logic          rsp_valid_q;
	res_t          rsp_q;

	bmhq_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	bmhq_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.res_free    (res_free),
		.res_valid   (res_valid),
		.res         (res)
	);

	assign res_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.out_key    = rsp_q.key;
	assign rsp.out_tag    = rsp_q.tag;
	assign rsp.status     = rsp_q.status;
	assign rsp.fill_count = rsp_q.fill;

endmodule

`default_nettype wire

### rtl/bmhq_mem.sv
// Heap entry store: one write port and one read port with registered read data.
// Depends on bmhq_pkg for the entry type.
`default_nettype none

module bmhq_mem import bmhq_pkg::*; #(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire entry_t        wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output entry_t             rd_data
);

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/bmhq_ctrl.sv
// Heap sequencer: sift-up and sift-down over the entry store with one shared
// key comparator. Depends on bmhq_pkg and bmhq_if; drives bmhq_mem.
`default_nettype none

module bmhq_ctrl import bmhq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	bmhq_req_if.sink           req,
	output logic               mem_wr_en,
	output logic [AW-1:0]      mem_wr_addr,
	output entry_t             mem_wr_data,
	output logic               mem_rd_en,
	output logic [AW-1:0]      mem_rd_addr,
	input  wire entry_t        mem_rd_data,
	input  wire logic          res_free,
	output logic               res_valid,
	output res_t               res
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_UP_RD   = 4'd1;
	localparam logic [3:0] S_UP_CMP  = 4'd2;
	localparam logic [3:0] S_RM_ROOT = 4'd3;
	localparam logic [3:0] S_RM_LAST = 4'd4;
	localparam logic [3:0] S_RM_GET  = 4'd5;
	localparam logic [3:0] S_DN_L    = 4'd6;
	localparam logic [3:0] S_DN_R    = 4'd7;
	localparam logic [3:0] S_DN_SEL  = 4'd8;
	localparam logic [3:0] S_DN_SWAP = 4'd9;
	localparam logic [3:0] S_DONE    = 4'd10;

	localparam logic [CNT_W-1:0] POS_ROOT = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

	logic [3:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    pos_q;
	logic [CNT_W-1:0]    child_pos_q;
	entry_t              cur_q;
	entry_t              child_q;
	logic [KEY_W-1:0]    res_key_q;
	logic [TAG_W-1:0]    res_tag_q;
	logic [STATUS_W-1:0] res_status_q;

	logic [CNT_W:0]      left_w;
	logic [CNT_W:0]      right_w;
	logic [CNT_W:0]      count_ext;
	logic [CNT_W-1:0]    parent_w;
	logic                left_out;
	logic                right_in;
	logic [KEY_W-1:0]    cmp_a;
	logic [KEY_W-1:0]    cmp_b;
	logic                cmp_lt;

	assign left_w    = {pos_q, 1'b0};
	assign right_w   = left_w + (CNT_W + 1)'(1);
	assign count_ext = {1'b0, count_q};
	assign parent_w  = pos_q >> 1;
	assign left_out  = left_w > count_ext;
	assign right_in  = right_w <= count_ext;

	always_comb begin
		unique case (state_q)
			S_UP_CMP: begin
				cmp_a = cur_q.key;
				cmp_b = mem_rd_data.key;
			end
			S_DN_SEL: begin
				cmp_a = mem_rd_data.key;
				cmp_b = child_q.key;
			end
			default: begin
				cmp_a = child_q.key;
				cmp_b = cur_q.key;
			end
		endcase
	end

	assign cmp_lt = cmp_a < cmp_b;

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = AW'(pos_q - POS_ROOT);
		mem_wr_data = cur_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		unique case (state_q)
			S_UP_RD: begin
				if (pos_q == POS_ROOT) begin
					mem_wr_en = 1'b1;
				end else begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = AW'(parent_w - POS_ROOT);
				end
			end
			S_UP_CMP: begin
				mem_wr_en   = 1'b1;
				mem_wr_data = cmp_lt ? mem_rd_data : cur_q;
			end
			S_RM_ROOT: begin
				mem_rd_en = 1'b1;
			end
			S_RM_LAST: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = AW'(count_q - POS_ROOT);
			end
			S_DN_L: begin
				if (left_out) begin
					mem_wr_en = 1'b1;
				end else begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = AW'(left_w - (CNT_W + 1)'(1));
				end
			end
			S_DN_R: begin
				if (right_in) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = AW'(right_w - (CNT_W + 1)'(1));
				end
			end
			S_DN_SWAP: begin
				mem_wr_en   = 1'b1;
				mem_wr_data = cmp_lt ? child_q : cur_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			pos_q        <= '0;
			child_pos_q  <= '0;
			cur_q        <= '0;
			child_q      <= '0;
			res_key_q    <= '0;
			res_tag_q    <= '0;
			res_status_q <= STATUS_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						res_key_q <= '0;
						res_tag_q <= '0;
						if (req.action == ACT_INSERT) begin
							if (count_q == CNT_FULL) begin
								res_status_q <= STATUS_FULL;
								state_q      <= S_DONE;
							end else begin
								res_status_q <= STATUS_OK;
								cur_q        <= '{key: req.key, tag: req.tag};
								count_q      <= count_q + POS_ROOT;
								pos_q        <= count_q + POS_ROOT;
								state_q      <= S_UP_RD;
							end
						end else if (count_q == '0) begin
							res_status_q <= STATUS_EMPTY;
							state_q      <= S_DONE;
						end else begin
							res_status_q <= STATUS_OK;
							state_q      <= S_RM_ROOT;
						end
					end
				end
				S_UP_RD: begin
					state_q <= (pos_q == POS_ROOT) ? S_DONE : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (cmp_lt) begin
						pos_q   <= parent_w;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RM_ROOT: begin
					state_q <= S_RM_LAST;
				end
				S_RM_LAST: begin
					res_key_q <= mem_rd_data.key;
					res_tag_q <= mem_rd_data.tag;
					count_q   <= count_q - POS_ROOT;
					state_q   <= S_RM_GET;
				end
				S_RM_GET: begin
					cur_q   <= mem_rd_data;
					pos_q   <= POS_ROOT;
					state_q <= (count_q == '0) ? S_DONE : S_DN_L;
				end
				S_DN_L: begin
					state_q <= left_out ? S_DONE : S_DN_R;
				end
				S_DN_R: begin
					child_q     <= mem_rd_data;
					child_pos_q <= CNT_W'(left_w);
					state_q     <= right_in ? S_DN_SEL : S_DN_SWAP;
				end
				S_DN_SEL: begin
					if (cmp_lt) begin
						child_q     <= mem_rd_data;
						child_pos_q <= CNT_W'(right_w);
					end
					state_q <= S_DN_SWAP;
				end
				S_DN_SWAP: begin
					if (cmp_lt) begin
						pos_q   <= child_pos_q;
						state_q <= S_DN_L;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready  = state_q == S_IDLE;
	assign res_valid  = (state_q == S_DONE) && res_free;
	assign res.key    = res_key_q;
	assign res.tag    = res_tag_q;
	assign res.status = res_status_q;
	assign res.fill   = FILL_W'(count_q);

endmodule

`default_nettype wire

### rtl/bmhq_chk.sv
// Port-level checker of the heap queue and its bind to the top level.
// Depends on bmhq_pkg and bmhq_if.
`default_nettype none

module bmhq_chk import bmhq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bmhq_req_if.sink  req,
	bmhq_rsp_if.source rsp
);

	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(CAPACITY);

	// A waiting response transaction keeps its valid until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> rsp.valid)
		else $error("response valid dropped before it was taken");

	// One request is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while the previous one is still at work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status == STATUS_OK || rsp.status == STATUS_EMPTY ||
		rsp.status == STATUS_FULL))
		else $error("undefined status code");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STATUS_EMPTY) |->
		(rsp.out_key == '0 && rsp.out_tag == '0 && rsp.fill_count == '0))
		else $error("empty removal reports data or entries");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STATUS_FULL) |->
		(rsp.fill_count == FILL_FULL && rsp.out_key == '0 && rsp.out_tag == '0))
		else $error("dropped insert reports a heap that is not full");

endmodule

bind binary_min_heap_queue bmhq_chk #(
	.CAPACITY (CAPACITY)
) u_bmhq_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

`default_nettype wire

### tb/binary_min_heap_queue_test.sv
// Self-checking testbench of the binary min-heap queue: directed and random inserts and
// removals, checked against a heap predictor held in the testbench.
// Depends on bmhq_pkg, bmhq_if and binary_min_heap_queue.
`default_nettype none

module binary_min_heap_queue_test;
	import bmhq_pkg::*;

	localparam int HEAP_DEPTH = CAPACITY_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int TAIL_CYCLES = 60;
	localparam int REPORT_LIMIT = 10;

	logic clk = 1'b0;
	logic arst_n;

	bmhq_req_if req_ch ();
	bmhq_rsp_if rsp_ch ();

	binary_min_heap_queue #(.CAPACITY(HEAP_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	entry_t slots [1:HEAP_DEPTH];
	int held = 0;
	res_t pending_results [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	function automatic res_t heap_predict(input logic act, input logic [KEY_W-1:0] k,
		input logic [TAG_W-1:0] t);
		res_t r;
		entry_t tmp;
		int pos;
		int pick;
		r = '0;
		if (act == ACT_INSERT) begin
			if (held >= HEAP_DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				held++;
				pos = held;
				slots[pos] = '{key: k, tag: t};
				while (pos > 1 && slots[pos].key < slots[pos / 2].key) begin
					tmp = slots[pos];
					slots[pos] = slots[pos / 2];
					slots[pos / 2] = tmp;
					pos = pos / 2;
				end
			end
		end else if (held == 0) begin
			r.status = STATUS_EMPTY;
		end else begin
			r.key = slots[1].key;
			r.tag = slots[1].tag;
			slots[1] = slots[held];
			held--;
			pos = 1;
			while (2 * pos <= held) begin
				pick = 2 * pos;
				if (pick + 1 <= held && slots[pick + 1].key < slots[pick].key)
					pick = pick + 1;
				if (slots[pos].key > slots[pick].key) begin
					tmp = slots[pos];
					slots[pos] = slots[pick];
					slots[pick] = tmp;
					pos = pick;
				end else begin
					break;
				end
			end
		end
		r.fill = FILL_W'(held);
		return r;
	endfunction

	// The valid line is left high after a transaction, so that a following item is
	// never lowered and raised again within one time step.
	task automatic send_item(input logic act, input logic [KEY_W-1:0] k,
		input logic [TAG_W-1:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.key <= k;
		req_ch.tag <= t;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_results.push_back(heap_predict(act, k, t));
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected response: key %h tag %h status %0d fill %0d",
						rsp_ch.out_key, rsp_ch.out_tag, rsp_ch.status, rsp_ch.fill_count);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.out_key !== want.key || rsp_ch.out_tag !== want.tag ||
					rsp_ch.status !== want.status || rsp_ch.fill_count !== want.fill) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("response mismatch: expected key %h tag %h status %0d",
							want.key, want.tag, want.status,
							" fill %0d, got key %h tag %h status %0d fill %0d",
							want.fill, rsp_ch.out_key, rsp_ch.out_tag, rsp_ch.status,
							rsp_ch.fill_count);
				end
			end
		end
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("binary_min_heap_queue_test failed");
			$finish;
		end
	end

	task automatic test_empty_removal();
		repeat (3)
			send_item(ACT_REMOVE, 16'hFFFF, 16'hFFFF);
	endtask

	// Equal keys carry distinct tags so that any movement of a tie shows in the order.
	task automatic test_extremes_and_ties();
		send_item(ACT_INSERT, 16'hFFFF, 16'hFFFF);
		send_item(ACT_INSERT, 16'h0000, 16'h0000);
		send_item(ACT_INSERT, 16'h0000, 16'h0001);
		send_item(ACT_INSERT, 16'hFFFF, 16'h0000);
		send_item(ACT_INSERT, 16'h8000, 16'hAAAA);
		send_item(ACT_INSERT, 16'h8000, 16'h5555);
		send_item(ACT_INSERT, 16'h0001, 16'hFFFF);
		send_item(ACT_INSERT, 16'h8000, 16'h0F0F);
		repeat (9)
			send_item(ACT_REMOVE, 16'h1234, 16'h5678);
	endtask

	task automatic test_full_heap();
		repeat (HEAP_DEPTH - held)
			send_item(ACT_INSERT, 16'($urandom()), 16'($urandom()));
		repeat (3)
			send_item(ACT_INSERT, 16'($urandom()), 16'($urandom()));
		send_item(ACT_REMOVE, 16'h0000, 16'h0000);
		send_item(ACT_INSERT, 16'h0000, 16'hBEEF);
		send_item(ACT_INSERT, 16'hFFFF, 16'hFFFF);
		repeat (HEAP_DEPTH + 2)
			send_item(ACT_REMOVE, 16'h0000, 16'h0000);
	endtask

	task automatic test_random_traffic(input int count, input int insert_pct,
		input int key_span);
		logic [KEY_W-1:0] k;
		repeat (count) begin
			k = (key_span == 0) ? 16'($urandom()) : 16'($urandom_range(key_span));
			if ($urandom_range(99) < insert_pct)
				send_item(ACT_INSERT, k, 16'($urandom()));
			else
				send_item(ACT_REMOVE, k, 16'($urandom()));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_INSERT;
		req_ch.key <= '0;
		req_ch.tag <= '0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_removal();
		test_extremes_and_ties();

		send_idle_pct = 17;
		recv_stall_pct = 17;
		test_full_heap();

		send_idle_pct = 45;
		recv_stall_pct = 0;
		test_random_traffic(150, 70, 0);
		send_idle_pct = 0;
		recv_stall_pct = 45;
		test_random_traffic(150, 40, 15);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(150, 55, 0);
		send_idle_pct = 17;
		recv_stall_pct = 17;
		test_random_traffic(150, 50, 3);

		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("binary_min_heap_queue_test passed");
		else
			$display("binary_min_heap_queue_test failed");
		$finish;
	end

endmodule

`default_nettype wire
